// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/e2q_pkg.sv =====
// package with constants, types and helpers for the euler to quaternion block
package e2q_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int PH_W = 32;
    localparam int CW = 34;                 // cordic x/y datapath width
    localparam int MUL_STAGES = 4;          // pipeline stages behind the cordic
    localparam int LAT = CORDIC_STAGES + 2 + MUL_STAGES;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032875);
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [PH_W-1:0] z;
        logic flip;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t p;
        cordic_lane_t ya;
        cordic_lane_t r;
    } cordic_cell_t;

    function automatic logic signed [PH_W-1:0] atan_turn(input int idx);
        logic signed [PH_W-1:0] v;
        begin
            case (idx)
                0: v = 32'sd536870912;
                1: v = 32'sd316933405;
                2: v = 32'sd167458907;
                3: v = 32'sd85004756;
                4: v = 32'sd42667331;
                5: v = 32'sd21354465;
                6: v = 32'sd10680862;
                7: v = 32'sd5340245;
                8: v = 32'sd2670163;
                9: v = 32'sd1335087;
                10: v = 32'sd667544;
                11: v = 32'sd333772;
                12: v = 32'sd166886;
                13: v = 32'sd83443;
                14: v = 32'sd41721;
                15: v = 32'sd20860;
                16: v = 32'sd10430;
                17: v = 32'sd5215;
                18: v = 32'sd2607;
                19: v = 32'sd1303;
                20: v = 32'sd651;
                21: v = 32'sd325;
                22: v = 32'sd162;
                23: v = 32'sd81;
                24: v = 32'sd40;
                25: v = 32'sd20;
                26: v = 32'sd10;
                27: v = 32'sd5;
                28: v = 32'sd2;
                29: v = 32'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // product of two q1.30 values rounded to q1.30
    function automatic logic signed [CW-1:0] mul_q30(input logic signed [CW-1:0] a,
                                                     input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        begin
            p = a * b + (2*CW)'(64'sd536870912);
            return CW'(p >>> 30);
        end
    endfunction

    function automatic logic [31:0] sat_q30(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        begin
            if (v > CW'(ONE_Q30))
                r = CW'(ONE_Q30);
            else if (v < -CW'(ONE_Q30))
                r = -CW'(ONE_Q30);
            else
                r = v;
            return r[31:0];
        end
    endfunction

endpackage

// ===== design/euler_to_quaternion_top.sv =====
// top level of the euler angle to quaternion converter
//
// channel  dir  fields (low bit first)
// s_axis   in   pitch_deg, yaw_deg, roll_deg (3 x 32)
// m_axis   out  quat_x, quat_y, quat_z, quat_w (4 x 32)
//
// one request per cycle unless the output stalls
// the pipeline is a row of cordic cells plus phase and product stages
// the whole pipe advances when the output register is empty or taken
// a stall freezes every stage; reset clears only the valid bits
module euler_to_quaternion_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // pitch_deg, yaw_deg, roll_deg
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // quat_x, quat_y, quat_z, quat_w
);
    localparam int N = e2q_pkg::CORDIC_STAGES;
    localparam int LAT = e2q_pkg::LAT;

    logic                  en;
    logic [LAT-1:0]        vld_reg;
    e2q_pkg::cordic_cell_t chain [N+1];

    // pipeline moves whenever the last stage can hand its result on
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    e2q_phase u_ph_p (.clk(clk), .en(en), .deg(s_axis_tdata[31:0]),  .lane_reg(chain[0].p));
    e2q_phase u_ph_y (.clk(clk), .en(en), .deg(s_axis_tdata[63:32]), .lane_reg(chain[0].ya));
    e2q_phase u_ph_r (.clk(clk), .en(en), .deg(s_axis_tdata[95:64]), .lane_reg(chain[0].r));

    // cordic cell row, one rotation per cell
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        e2q_cell u_cell (
            .clk(clk), .en(en), .idx(5'(i)),
            .din(chain[i]), .dout_reg(chain[i+1])
        );
    end

    e2q_combine u_comb (.clk(clk), .en(en), .din(chain[N]), .quat_reg(m_axis_tdata));
endmodule

// ===== design/e2q_phase.sv =====
// degree to folded binary phase conversion, two registered stages per lane
module e2q_phase (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [31:0]        deg,
    output e2q_pkg::cordic_lane_t     lane_reg
);
    // phase = floor((deg*65536 + 360) / 720) mod 2^32
    // with u = deg + 720*2^22 (always positive) this is floor((4096*u + 22) / 45)
    // 4096 = 1 mod 45, so floor((4096*h + l) / 45) = 91*h + floor((h + l) / 45)
    // two such folds leave a 13 bit value divided by 45 via reciprocal multiply
    logic [33:0]        u;
    logic [32:0]        w;
    logic [31:0]        base_next;
    logic [31:0]        base_reg;
    logic [21:0]        t_next;
    logic [21:0]        t_reg;
    logic [12:0]        s;
    logic [25:0]        sm;
    logic [31:0]        q;
    logic [31:0]        ph;
    logic               flip;
    e2q_pkg::cordic_lane_t lane_next;

    // stage a: offset, first fold
    always_comb
    begin
        u         = {{2{deg[31]}}, deg} + 34'd3019898880;
        w         = u[32:0] + 33'd22;
        base_next = u[31:0] * 32'd91 + 32'(w[32:12]) * 32'd91;
        t_next    = {1'b0, w[32:12]} + {10'd0, w[11:0]};
    end

    // stage b: second fold, small divide and quadrant fold
    always_comb
    begin
        s    = {3'd0, t_reg[21:12]} + {1'b0, t_reg[11:0]};
        // floor(s/45) = (s*5826) >> 18, exact for s below 10082
        sm   = {13'd0, s} * 26'd5826;
        q    = base_reg + 32'(t_reg[21:12]) * 32'd91 + {24'd0, sm[25:18]};
        ph   = q;
        flip = (ph[31:30] == 2'b01) || (ph[31:30] == 2'b10);
        if (flip)
            ph[31] = ~ph[31];
        lane_next.x    = e2q_pkg::CORDIC_GAIN;
        lane_next.y    = '0;
        lane_next.z    = $signed(ph);
        lane_next.flip = flip;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            base_reg <= base_next;
            t_reg    <= t_next;
            lane_reg <= lane_next;
        end
    end
endmodule

// ===== design/e2q_cell.sv =====
// one cordic rotation cell for the three angle lanes
module e2q_cell (
    input  logic                  clk,
    input  logic                  en,
    input  logic [4:0]            idx,
    input  e2q_pkg::cordic_cell_t din,
    output e2q_pkg::cordic_cell_t dout_reg
);
    e2q_pkg::cordic_cell_t dout_next;
    logic signed [31:0] at;

    function automatic e2q_pkg::cordic_lane_t rot(input e2q_pkg::cordic_lane_t l,
                                                  input logic [4:0] s,
                                                  input logic signed [31:0] a);
        e2q_pkg::cordic_lane_t o;
        begin
            o = l;
            if (!l.z[31])
            begin
                o.x = l.x - (l.y >>> s);
                o.y = l.y + (l.x >>> s);
                o.z = l.z - a;
            end
            else
            begin
                o.x = l.x + (l.y >>> s);
                o.y = l.y - (l.x >>> s);
                o.z = l.z + a;
            end
            return o;
        end
    endfunction

    always_comb
    begin
        at = e2q_pkg::atan_turn(int'(idx));
        dout_next.p  = rot(din.p, idx, at);
        dout_next.ya = rot(din.ya, idx, at);
        dout_next.r  = rot(din.r, idx, at);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dout_reg <= dout_next;
    end
endmodule

// ===== design/e2q_combine.sv =====
// quaternion cross products and saturation, pipelined
module e2q_combine (
    input  logic                  clk,
    input  logic                  en,
    input  e2q_pkg::cordic_cell_t din,
    output logic [127:0]          quat_reg
);
    localparam int CW = e2q_pkg::CW;
    logic signed [CW-1:0] ps_reg, pc_reg, ys_reg, yc_reg, rs_reg, rc_reg;
    logic signed [CW-1:0] a_reg, b_reg, c_reg, d_reg, ys2_reg, yc2_reg;
    logic signed [CW-1:0] m_reg [8];
    logic signed [CW-1:0] ps_n, pc_n, ys_n, yc_n, rs_n, rc_n;

    always_comb
    begin
        ps_n = din.p.flip ? -din.p.y : din.p.y;
        pc_n = din.p.flip ? -din.p.x : din.p.x;
        ys_n = din.ya.flip ? -din.ya.y : din.ya.y;
        yc_n = din.ya.flip ? -din.ya.x : din.ya.x;
        rs_n = din.r.flip ? -din.r.y : din.r.y;
        rc_n = din.r.flip ? -din.r.x : din.r.x;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg <= ps_n; pc_reg <= pc_n; ys_reg <= ys_n;
            yc_reg <= yc_n; rs_reg <= rs_n; rc_reg <= rc_n;
            a_reg <= e2q_pkg::mul_q30(rs_reg, pc_reg);
            b_reg <= e2q_pkg::mul_q30(rc_reg, pc_reg);
            c_reg <= e2q_pkg::mul_q30(rs_reg, ps_reg);
            d_reg <= e2q_pkg::mul_q30(rc_reg, ps_reg);
            ys2_reg <= ys_reg; yc2_reg <= yc_reg;
            m_reg[0] <= e2q_pkg::mul_q30(d_reg, ys2_reg);
            m_reg[1] <= e2q_pkg::mul_q30(a_reg, yc2_reg);
            m_reg[2] <= e2q_pkg::mul_q30(d_reg, yc2_reg);
            m_reg[3] <= e2q_pkg::mul_q30(a_reg, ys2_reg);
            m_reg[4] <= e2q_pkg::mul_q30(c_reg, yc2_reg);
            m_reg[5] <= e2q_pkg::mul_q30(b_reg, ys2_reg);
            m_reg[6] <= e2q_pkg::mul_q30(b_reg, yc2_reg);
            m_reg[7] <= e2q_pkg::mul_q30(c_reg, ys2_reg);
            quat_reg <= {e2q_pkg::sat_q30(m_reg[6] + m_reg[7]),
                         e2q_pkg::sat_q30(m_reg[4] - m_reg[5]),
                         e2q_pkg::sat_q30(-m_reg[2] - m_reg[3]),
                         e2q_pkg::sat_q30(m_reg[0] - m_reg[1])};
        end
    end
endmodule

// ===== design/e2q_checker.sv =====
// port-level checker for the euler to quaternion block
`include "assert_macros.svh"
module e2q_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    `ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `ASSERT_IMPL(a_ready, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `ASSERT_IMPL(a_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `ASSERT_IMPL(a_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[31:30] != 2'b10 || m_axis_tdata[29:0] == 30'd0)
endmodule

bind euler_to_quaternion_top e2q_checker u_chk (.*);
